// ===== design/ssc_pkg.sv =====
// Shared types, codes and constants for the slice statistics cursor lookup.
// Used by the channel interfaces, the datapath modules and the checker.
package ssc_pkg;

  localparam int SLICE_W = 31;
  localparam int KEY_W = 64;
  localparam int SLOT_W = 6;
  localparam int ACTION_W = 2;
  localparam int DIR_W = 2;
  localparam int SLOT_SPAN = 2 ** SLOT_W;
  localparam int TABLE_ENTRIES_DEF = 64;

  typedef logic [SLICE_W-1:0] slice_t;
  typedef logic [KEY_W-1:0] key_t;

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [DIR_W-1:0] DIR_NEXT = 2'd0;
  localparam logic [DIR_W-1:0] DIR_PREV = 2'd1;
  localparam logic [DIR_W-1:0] DIR_FIRST = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LAST = 2'd3;

  typedef struct packed {
    slice_t slice;
    key_t   low_key;
    key_t   high_key;
  } entry_t;

  typedef struct packed {
    logic   any;
    slice_t lo;
    slice_t hi;
    logic   have_cur;
    key_t   cur_min;
    key_t   cur_max;
    logic   have_up;
    slice_t up;
    logic   have_down;
    slice_t down;
  } acc_t;

endpackage

// ===== design/ssc_in_if.sv =====
// Request channel carrying one table command or cursor query.
// Depends on ssc_pkg for field widths.
interface ssc_in_if;
  logic                          valid;
  logic                          ready;
  logic [ssc_pkg::ACTION_W-1:0]  action;
  logic [ssc_pkg::SLOT_W-1:0]    slot;
  logic [ssc_pkg::SLICE_W-1:0]   entry_slice;
  logic [ssc_pkg::KEY_W-1:0]     entry_min;
  logic [ssc_pkg::KEY_W-1:0]     entry_max;
  logic [ssc_pkg::SLICE_W-1:0]   query_slice;
  logic [ssc_pkg::KEY_W-1:0]     key_value;
  logic [ssc_pkg::DIR_W-1:0]     direction;

  modport source (output valid, action, slot, entry_slice, entry_min, entry_max,
                  query_slice, key_value, direction, input ready);
  modport sink (input valid, action, slot, entry_slice, entry_min, entry_max,
                query_slice, key_value, direction, output ready);
endinterface

// ===== design/ssc_out_if.sv =====
// Result channel carrying the slice chosen by a cursor query.
// Depends on ssc_pkg for the slice width.
interface ssc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssc_pkg::SLICE_W-1:0] found_slice;

  modport source (output valid, found_slice, input ready);
  modport sink (input valid, found_slice, output ready);
endinterface

// ===== design/ssc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module ssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ssc_scan_unit.sv =====
// Compare unit that folds one table entry into the running query accumulator.
// Depends on ssc_pkg for the entry and accumulator types.
module ssc_scan_unit (
  input  ssc_pkg::acc_t   acc_i,
  input  logic            ent_valid,
  input  ssc_pkg::entry_t ent,
  input  ssc_pkg::slice_t cur,
  output ssc_pkg::acc_t   acc_o
);

  ssc_pkg::slice_t s;

  assign s = ent.slice;

  always_comb begin
    acc_o = acc_i;
    if (ent_valid) begin
      if (!acc_i.any) begin
        acc_o.any = 1'b1;
        acc_o.lo = s;
        acc_o.hi = s;
      end else begin
        if (s < acc_i.lo) begin
          acc_o.lo = s;
        end
        if (s > acc_i.hi) begin
          acc_o.hi = s;
        end
      end
      if (s == cur && !acc_i.have_cur) begin
        acc_o.have_cur = 1'b1;
        acc_o.cur_min = ent.low_key;
        acc_o.cur_max = ent.high_key;
      end
      if (s > cur && (!acc_i.have_up || s < acc_i.up)) begin
        acc_o.have_up = 1'b1;
        acc_o.up = s;
      end
      if (s < cur && (!acc_i.have_down || s > acc_i.down)) begin
        acc_o.have_down = 1'b1;
        acc_o.down = s;
      end
    end
  end

endmodule

// ===== design/slice_stat_cursor_lookup.sv =====
// Top level of the slice statistics table with cursor queries.
// Depends on ssc_pkg, ssc_in_if, ssc_out_if, ssc_ram and ssc_scan_unit.
//
//   Channel | Dir | Carries
//   in_ch   | in  | action, slot, entry fields, query_slice, key_value, direction
//   out_ch  | out | found_slice, one per cursor query
//
// Clear and write requests finish in the cycle they are accepted.
// A cursor query reads min(TABLE_ENTRIES, 64) slots, one table read per cycle through
// the RAM read port, folds each registered read word in and then picks the answer.
// Reset clears all valid bits at once, so no clearing pass is needed.
// A finished answer waits in the output register while new requests are taken.
module slice_stat_cursor_lookup #(
  parameter int TABLE_ENTRIES = ssc_pkg::TABLE_ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ssc_in_if.sink    in_ch,
  ssc_out_if.source out_ch
);

  localparam int DEPTH = (TABLE_ENTRIES < ssc_pkg::SLOT_SPAN) ?
                         TABLE_ENTRIES : ssc_pkg::SLOT_SPAN;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [DEPTH-1:0]            valid_r, valid_nxt;
  logic [AW-1:0]               cnt_r, cnt_nxt;
  logic                        issue_r, issue_nxt;
  logic                        pend_r, pend_nxt;
  logic                        last_r, last_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  ssc_pkg::acc_t               acc_r, acc_nxt, acc_upd;
  ssc_pkg::slice_t             cur_r, cur_nxt;
  ssc_pkg::key_t               key_r, key_nxt;
  logic [ssc_pkg::DIR_W-1:0]   dir_r, dir_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ssc_pkg::slice_t             out_slice_r, out_slice_nxt;

  logic                        in_acc;
  logic                        slot_ok;
  logic                        ram_we;
  logic [AW-1:0]               slot_addr;
  ssc_pkg::entry_t             wr_ent;
  ssc_pkg::entry_t             rd_ent;
  logic [$bits(ssc_pkg::entry_t)-1:0] rd_bits;
  ssc_pkg::slice_t             answer;
  logic                        out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign slot_ok = (32'(in_ch.slot) < TABLE_ENTRIES);
  assign slot_addr = in_ch.slot[AW-1:0];
  assign ram_we = in_acc && (in_ch.action == ssc_pkg::ACT_WRITE) && slot_ok;
  assign wr_ent.slice = in_ch.entry_slice;
  assign wr_ent.low_key = in_ch.entry_min;
  assign wr_ent.high_key = in_ch.entry_max;
  assign rd_ent = ssc_pkg::entry_t'(rd_bits);
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.found_slice = out_slice_r;

  ssc_ram #(
    .WIDTH($bits(ssc_pkg::entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_addr),
    .wdata(wr_ent),
    .re   (issue_r),
    .raddr(cnt_r),
    .rdata(rd_bits)
  );

  ssc_scan_unit u_scan (
    .acc_i    (acc_r),
    .ent_valid(rd_vld_r),
    .ent      (rd_ent),
    .cur      (cur_r),
    .acc_o    (acc_upd)
  );

  always_comb begin
    answer = '0;
    if (acc_r.any) begin
      unique case (dir_r)
        ssc_pkg::DIR_NEXT: begin
          if (acc_r.have_cur && acc_r.cur_max > key_r) begin
            answer = cur_r;
          end else if (acc_r.have_up) begin
            answer = acc_r.up;
          end
        end
        ssc_pkg::DIR_PREV: begin
          if (acc_r.have_cur && acc_r.cur_min < key_r) begin
            answer = cur_r;
          end else if (acc_r.have_down) begin
            answer = acc_r.down;
          end
        end
        ssc_pkg::DIR_FIRST: answer = acc_r.lo;
        ssc_pkg::DIR_LAST: answer = acc_r.hi;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    cnt_nxt = cnt_r;
    issue_nxt = 1'b0;
    pend_nxt = 1'b0;
    last_nxt = 1'b0;
    rd_vld_nxt = 1'b0;
    acc_nxt = acc_r;
    cur_nxt = cur_r;
    key_nxt = key_r;
    dir_nxt = dir_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_slice_nxt = out_slice_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.action)
            ssc_pkg::ACT_CLEAR: valid_nxt = '0;
            ssc_pkg::ACT_WRITE: begin
              if (slot_ok) begin
                valid_nxt[slot_addr] = 1'b1;
              end
            end
            ssc_pkg::ACT_QUERY: begin
              state_nxt = ST_SCAN;
              cnt_nxt = '0;
              issue_nxt = 1'b1;
              acc_nxt = '0;
              cur_nxt = in_ch.query_slice;
              key_nxt = in_ch.key_value;
              dir_nxt = in_ch.direction;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue_r) begin
          pend_nxt = 1'b1;
          rd_vld_nxt = valid_r[cnt_r];
          last_nxt = (cnt_r == LAST_ADDR);
          issue_nxt = (cnt_r != LAST_ADDR);
          cnt_nxt = cnt_r + AW'(1);
        end
        if (pend_r) begin
          acc_nxt = acc_upd;
          if (last_r) begin
            state_nxt = ST_RESOLVE;
          end
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slice_nxt = answer;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      issue_r <= 1'b0;
      pend_r <= 1'b0;
      last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      issue_r <= issue_nxt;
      pend_r <= pend_nxt;
      last_r <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rd_vld_r <= rd_vld_nxt;
    acc_r <= acc_nxt;
    cur_r <= cur_nxt;
    key_r <= key_nxt;
    dir_r <= dir_nxt;
    out_slice_r <= out_slice_nxt;
  end

endmodule

// ===== design/ssc_checker.sv =====
// Port-level checker for slice_stat_cursor_lookup and the bind that attaches it.
// Depends on ssc_pkg for the request action codes.
module ssc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [ssc_pkg::ACTION_W-1:0] in_action,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ssc_pkg::SLICE_W-1:0]  out_found_slice
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_slice))
    else $error("Result changed or dropped while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result shown right after reset.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action != ssc_pkg::ACT_QUERY && !out_valid |=> !out_valid)
    else $error("Result appeared for a request that gives none.");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == ssc_pkg::ACT_QUERY |=> !in_ready)
    else $error("New request taken while a query was running.");

endmodule

bind slice_stat_cursor_lookup ssc_checker u_ssc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_action      (in_ch.action),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_found_slice(out_ch.found_slice)
);

// ===== test/slice_stat_cursor_lookup_tb.sv =====
// Self-checking testbench for slice_stat_cursor_lookup: directed table rows, then random
// table writes, clears and cursor queries under several sender and receiver idle patterns.
// Depends on ssc_pkg, ssc_in_if, ssc_out_if and the slice_stat_cursor_lookup RTL.
module slice_stat_cursor_lookup_tb;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_PER_PHASE = 350;
  localparam int PHASES = 4;
  localparam int IDLE_PLAN [PHASES] = '{0, 78, 0, 29};
  localparam int STALL_PLAN [PHASES] = '{0, 0, 78, 29};
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS = 10;
  localparam int ENTRIES = ssc_pkg::TABLE_ENTRIES_DEF;
  localparam logic [ssc_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam ssc_pkg::key_t KEY_TOP = '1;
  localparam ssc_pkg::slice_t SLICE_TOP = '1;

  typedef struct packed {
    logic [ssc_pkg::ACTION_W-1:0] action;
    logic [ssc_pkg::SLOT_W-1:0]   slot;
    ssc_pkg::slice_t              entry_slice;
    ssc_pkg::key_t                entry_min;
    ssc_pkg::key_t                entry_max;
    ssc_pkg::slice_t              query_slice;
    ssc_pkg::key_t                key_value;
    logic [ssc_pkg::DIR_W-1:0]    direction;
    logic                         pinned;
    ssc_pkg::slice_t              pinned_found;
  } lookup_req_t;

  bit clk;
  logic rst_n;

  ssc_in_if in_ch ();
  ssc_out_if out_ch ();

  slice_stat_cursor_lookup dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic            model_valid [ENTRIES];
  ssc_pkg::slice_t model_slice [ENTRIES];
  ssc_pkg::key_t   model_low [ENTRIES];
  ssc_pkg::key_t   model_high [ENTRIES];

  ssc_pkg::slice_t expected_found [$];
  lookup_req_t     drive_req;
  lookup_req_t     directed_rows [DIRECTED_ROWS];
  int              sender_idle_pct;
  int              sink_stall_pct;
  int              mismatch_count;
  int              cycle_count;

  assign in_ch.action      = drive_req.action;
  assign in_ch.slot        = drive_req.slot;
  assign in_ch.entry_slice = drive_req.entry_slice;
  assign in_ch.entry_min   = drive_req.entry_min;
  assign in_ch.entry_max   = drive_req.entry_max;
  assign in_ch.query_slice = drive_req.query_slice;
  assign in_ch.key_value   = drive_req.key_value;
  assign in_ch.direction   = drive_req.direction;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic ssc_pkg::slice_t lookup_answer(ssc_pkg::slice_t cur, ssc_pkg::key_t key,
                                                    logic [ssc_pkg::DIR_W-1:0] dir);
    logic            any, have_cur, have_up, have_down;
    ssc_pkg::key_t   cur_min, cur_max;
    ssc_pkg::slice_t lo, hi, up, down, s;
    any = 1'b0;
    have_cur = 1'b0;
    have_up = 1'b0;
    have_down = 1'b0;
    cur_min = '0;
    cur_max = '0;
    lo = '0;
    hi = '0;
    up = '0;
    down = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (model_valid[i]) begin
        s = model_slice[i];
        if (!any || s < lo) lo = s;
        if (!any || s > hi) hi = s;
        any = 1'b1;
        if (s == cur && !have_cur) begin
          have_cur = 1'b1;
          cur_min = model_low[i];
          cur_max = model_high[i];
        end
        if (s > cur && (!have_up || s < up)) begin
          up = s;
          have_up = 1'b1;
        end
        if (s < cur && (!have_down || s > down)) begin
          down = s;
          have_down = 1'b1;
        end
      end
    end
    if (!any) return '0;
    case (dir)
      ssc_pkg::DIR_NEXT: begin
        if (have_cur && cur_max > key) return cur;
        return have_up ? up : '0;
      end
      ssc_pkg::DIR_PREV: begin
        if (have_cur && cur_min < key) return cur;
        return have_down ? down : '0;
      end
      ssc_pkg::DIR_FIRST: return lo;
      default: return hi;
    endcase
  endfunction

  function automatic lookup_req_t mk_cmd(logic [ssc_pkg::ACTION_W-1:0] act);
    lookup_req_t r;
    r = '1;
    r.action = act;
    r.pinned = 1'b0;
    return r;
  endfunction

  function automatic lookup_req_t mk_write(int unsigned slot, ssc_pkg::slice_t s,
                                           ssc_pkg::key_t lo, ssc_pkg::key_t hi);
    lookup_req_t r;
    r = '0;
    r.action = ssc_pkg::ACT_WRITE;
    r.slot = ssc_pkg::SLOT_W'(slot);
    r.entry_slice = s;
    r.entry_min = lo;
    r.entry_max = hi;
    return r;
  endfunction

  function automatic lookup_req_t mk_query(ssc_pkg::slice_t cur, ssc_pkg::key_t key,
                                           logic [ssc_pkg::DIR_W-1:0] dir,
                                           logic pin, ssc_pkg::slice_t found);
    lookup_req_t r;
    r = '0;
    r.action = ssc_pkg::ACT_QUERY;
    r.query_slice = cur;
    r.key_value = key;
    r.direction = dir;
    r.pinned = pin;
    r.pinned_found = found;
    return r;
  endfunction

  function automatic ssc_pkg::slice_t pick_slice();
    case ($urandom_range(9))
      0: return SLICE_TOP;
      1: return ssc_pkg::slice_t'(1);
      2, 3: return ssc_pkg::slice_t'($urandom);
      default: return ssc_pkg::slice_t'($urandom_range(24, 1));
    endcase
  endfunction

  function automatic ssc_pkg::key_t pick_key(int unsigned ref_slot);
    case ($urandom_range(7))
      0: return '0;
      1: return KEY_TOP;
      2: return {$urandom, $urandom};
      3: return model_low[ref_slot] + ssc_pkg::key_t'($urandom_range(2)) - 1;
      4: return model_high[ref_slot] + ssc_pkg::key_t'($urandom_range(2)) - 1;
      default: return ssc_pkg::key_t'($urandom_range(1000));
    endcase
  endfunction

  // Mostly writes and queries around slices already in the table, so that current-entry
  // hits, duplicates and neighbor searches all occur; clears keep the table turning over.
  function automatic lookup_req_t random_request();
    lookup_req_t r;
    int unsigned pick, ref_slot;
    pick = $urandom_range(99);
    ref_slot = $urandom_range(ENTRIES - 1);
    r.slot = ssc_pkg::SLOT_W'($urandom);
    r.entry_slice = pick_slice();
    if ($urandom_range(3) == 0) begin
      r.entry_min = pick_key(ref_slot);
      r.entry_max = pick_key(ref_slot);
    end else begin
      r.entry_min = ssc_pkg::key_t'($urandom_range(1000));
      r.entry_max = r.entry_min + ssc_pkg::key_t'($urandom_range(1000));
    end
    if ($urandom_range(2) != 0)
      r.query_slice = model_slice[ref_slot] + ssc_pkg::slice_t'($urandom_range(2)) - 1'b1;
    else if ($urandom_range(4) == 0)
      r.query_slice = '0;
    else
      r.query_slice = pick_slice();
    r.key_value = pick_key(ref_slot);
    r.direction = ssc_pkg::DIR_W'($urandom);
    r.pinned = 1'b0;
    r.pinned_found = '0;
    if (pick < 2)
      r.action = ssc_pkg::ACT_CLEAR;
    else if (pick < 5)
      r.action = ACT_SPARE;
    else if (pick < 40)
      r.action = ssc_pkg::ACT_WRITE;
    else
      r.action = ssc_pkg::ACT_QUERY;
    return r;
  endfunction

  task automatic send_request(lookup_req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    drive_req <= r;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    ssc_pkg::slice_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_found.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("found_slice %0d arrived with no query outstanding", out_ch.found_slice);
        end else begin
          want = expected_found.pop_front();
          if (out_ch.found_slice !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("found_slice mismatch: expected %0d, got %0d", want, out_ch.found_slice);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (drive_req.action)
          ssc_pkg::ACT_CLEAR: begin
            foreach (model_valid[i]) model_valid[i] = 1'b0;
          end
          ssc_pkg::ACT_WRITE: begin
            model_valid[drive_req.slot] = 1'b1;
            model_slice[drive_req.slot] = drive_req.entry_slice;
            model_low[drive_req.slot] = drive_req.entry_min;
            model_high[drive_req.slot] = drive_req.entry_max;
          end
          ssc_pkg::ACT_QUERY: begin
            expected_found.push_back(drive_req.pinned ? drive_req.pinned_found :
                lookup_answer(drive_req.query_slice, drive_req.key_value,
                              drive_req.direction));
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("slice_stat_cursor_lookup verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    drive_req = '0;
    sender_idle_pct = 0;
    sink_stall_pct = 0;
    mismatch_count = 0;
    cycle_count = 0;
    foreach (model_valid[i]) begin
      model_valid[i] = 1'b0;
      model_slice[i] = '0;
      model_low[i] = '0;
      model_high[i] = '0;
    end
    directed_rows = '{
      mk_query('0, '0, ssc_pkg::DIR_FIRST, 1'b1, '0),
      mk_query(SLICE_TOP, KEY_TOP, ssc_pkg::DIR_NEXT, 1'b1, '0),
      mk_query(5, 7, ssc_pkg::DIR_LAST, 1'b1, '0),
      mk_cmd(ACT_SPARE),
      mk_write(0, 100, 10, 20),
      mk_write(63, SLICE_TOP, '0, KEY_TOP),
      mk_write(5, 1, KEY_TOP, '0),
      mk_write(6, 100, '0, KEY_TOP),
      mk_query('0, '0, ssc_pkg::DIR_FIRST, 1'b1, 1),
      mk_query('0, '0, ssc_pkg::DIR_LAST, 1'b1, SLICE_TOP),
      mk_query(100, 15, ssc_pkg::DIR_NEXT, 1'b1, 100),
      mk_query(100, 20, ssc_pkg::DIR_NEXT, 1'b1, SLICE_TOP),
      mk_query(100, 10, ssc_pkg::DIR_PREV, 1'b1, 1),
      mk_query(100, 11, ssc_pkg::DIR_PREV, 1'b1, 100),
      mk_query(SLICE_TOP, KEY_TOP, ssc_pkg::DIR_NEXT, 1'b1, '0),
      mk_query(1, KEY_TOP, ssc_pkg::DIR_PREV, 1'b1, '0),
      mk_query(50, '0, ssc_pkg::DIR_NEXT, 1'b0, '0),
      mk_query('0, '0, ssc_pkg::DIR_PREV, 1'b0, '0),
      mk_write(0, 200, '0, '0),
      mk_query(100, '0, ssc_pkg::DIR_NEXT, 1'b0, '0),
      mk_query(300, 5, ssc_pkg::DIR_PREV, 1'b0, '0),
      mk_cmd(ssc_pkg::ACT_CLEAR),
      mk_query('0, '0, ssc_pkg::DIR_LAST, 1'b1, '0),
      mk_write(31, 31'h4000_0000, 5, 5),
      mk_query('0, KEY_TOP, ssc_pkg::DIR_NEXT, 1'b0, '0)
    };
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) send_request(directed_rows[i]);
    for (int phase = 0; phase < PHASES; phase++) begin
      sender_idle_pct = IDLE_PLAN[phase];
      sink_stall_pct = STALL_PLAN[phase];
      repeat (RANDOM_PER_PHASE) send_request(random_request());
      in_ch.valid <= 1'b0;
      do @(negedge clk); while (expected_found.size() != 0);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("slice_stat_cursor_lookup verification clean");
    else
      $display("slice_stat_cursor_lookup verification failed");
    $finish;
  end

endmodule
